[rtl/tdoa_sound_direction_finder_unit_defines.svh]
// Assertion helpers shared by the RTL files.
// The clock and reset of the using module are clk_i and rst_ni.
`ifndef TDOA_SOUND_DIRECTION_FINDER_UNIT_DEFINES_SVH
`define TDOA_SOUND_DIRECTION_FINDER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define TDOA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tdoa: same-cycle check failed");

// Next-cycle implication.
`define TDOA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tdoa: next-cycle check failed");

`endif

[rtl/tdoa_sdf_pkg.sv]
`timescale 1ns / 1ps

package tdoa_sdf_pkg;

  localparam int GRID_HALF = 30;
  localparam int TIME_BITS = 32;

  localparam int CFG_W     = 17;
  localparam int CFG_IDX_W = 2;
  localparam int TP_W      = 17;
  localparam int TPU_W     = 16;
  localparam int THR_W     = 17;
  localparam int RC_W      = 16;

  localparam int ANG_W = 17;
  localparam int ROT_W = 18;
  localparam int XY_W  = 6;
  localparam int ERR_W = 20;

  localparam int NO_MATCH    = 1000000;
  localparam int FULL_CIRCLE = 92160;
  localparam int QUARTER     = 23040;

  localparam int CRD_STEPS = 16;
  localparam int CRD_FRAC  = 20;
  localparam int ATAN_W    = 22;

  localparam logic [TP_W-1:0]  TP_RESET  = TP_W'(16000);
  localparam logic [TPU_W-1:0] TPU_RESET = TPU_W'(7059);
  localparam logic [THR_W-1:0] THR_RESET = THR_W'(1280);

  typedef enum logic [1:0] {
    OP_ROLLOVER = 2'd0,
    OP_MIC1     = 2'd1,
    OP_MIC2     = 2'd2,
    OP_MIC3     = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CFG_TIMER_PERIOD    = 2'd0,
    CFG_TICKS_PER_UNIT  = 2'd1,
    CFG_ANGLE_THRESHOLD = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_SEARCH,
    S_DRAIN,
    S_ANGLE,
    S_MAP,
    S_DONE
  } state_e;

  typedef struct packed {
    logic accept;
    logic prep;
    logic issue;
    logic cordic_start;
    logic cordic_step;
    logic map;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic triple;
    logic gen_last;
    logic pipe_empty;
    logic cordic_last;
    logic out_free;
  } sts_t;

  // arctan(2^-i) in 1/65536 degree
  function automatic logic [ATAN_W-1:0] atan_entry(input logic [3:0] i);
    logic [ATAN_W-1:0] a;
    case (i)
      4'd0:    a = ATAN_W'(2949120);
      4'd1:    a = ATAN_W'(1740967);
      4'd2:    a = ATAN_W'(919879);
      4'd3:    a = ATAN_W'(466945);
      4'd4:    a = ATAN_W'(234379);
      4'd5:    a = ATAN_W'(117305);
      4'd6:    a = ATAN_W'(58666);
      4'd7:    a = ATAN_W'(29335);
      4'd8:    a = ATAN_W'(14668);
      4'd9:    a = ATAN_W'(7334);
      4'd10:   a = ATAN_W'(3667);
      4'd11:   a = ATAN_W'(1833);
      4'd12:   a = ATAN_W'(917);
      4'd13:   a = ATAN_W'(458);
      4'd14:   a = ATAN_W'(229);
      4'd15:   a = ATAN_W'(115);
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

[rtl/tdoa_sdf_ifs.sv]
`timescale 1ns / 1ps

interface tdoa_sdf_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [15:0] timer_value;

  modport source (output valid, output opcode, output timer_value, input ready);
  modport sink   (input valid, input opcode, input timer_value, output ready);
endinterface

interface tdoa_sdf_out_if;
  logic               valid;
  logic               ready;
  logic [16:0]        angle_deg;
  logic signed [17:0] rotate_deg;
  logic signed [5:0]  best_x;
  logic signed [5:0]  best_y;
  logic [19:0]        min_error;

  modport source (output valid, output angle_deg, output rotate_deg, output best_x,
                  output best_y, output min_error, input ready);
  modport sink   (input valid, input angle_deg, input rotate_deg, input best_x,
                  input best_y, input min_error, output ready);
endinterface

[rtl/tdoa_sdf_datapath.sv]
`timescale 1ns / 1ps
`include "tdoa_sound_direction_finder_unit_defines.svh"

module tdoa_sdf_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  tdoa_sdf_pkg::cmd_t                  cmd_i,
  output tdoa_sdf_pkg::sts_t                  sts_o,
  input  logic [1:0]                          opcode_i,
  input  logic [15:0]                         timer_value_i,
  input  logic                                cfg_we_i,
  input  logic [tdoa_sdf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tdoa_sdf_pkg::CFG_W-1:0]      cfg_wdata_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic [tdoa_sdf_pkg::ANG_W-1:0]      angle_deg_o,
  output logic signed [tdoa_sdf_pkg::ROT_W-1:0] rotate_deg_o,
  output logic signed [tdoa_sdf_pkg::XY_W-1:0] best_x_o,
  output logic signed [tdoa_sdf_pkg::XY_W-1:0] best_y_o,
  output logic [tdoa_sdf_pkg::ERR_W-1:0]      min_error_o
);

  localparam int G     = tdoa_sdf_pkg::GRID_HALF;
  localparam int TB    = tdoa_sdf_pkg::TIME_BITS;
  localparam int CW    = $clog2(G + 2) + 1;
  localparam int SQW   = $clog2(2 * (G + 1) * (G + 1) + 1);
  localparam int VW    = SQW + 16;
  localparam int NSTEP = (VW + 1) / 2;
  localparam int RW    = VW + 1;
  localparam int DW    = NSTEP;
  localparam int NS    = NSTEP + 4;
  localparam int PW    = DW + 1 + tdoa_sdf_pkg::TPU_W + 1;
  localparam int TW    = TB + 8;
  localparam int EW    = TW + 1;
  localparam int SUMW  = EW + 2 - 8;
  localparam int CRW   = tdoa_sdf_pkg::CRD_FRAC + CW + 2;
  localparam int ZW    = tdoa_sdf_pkg::ATAN_W + 3;
  localparam int ITW   = $clog2(tdoa_sdf_pkg::CRD_STEPS);
  localparam int AW    = tdoa_sdf_pkg::ANG_W;
  localparam int ERRW  = tdoa_sdf_pkg::ERR_W;
  localparam int PRODW = tdoa_sdf_pkg::RC_W + tdoa_sdf_pkg::TP_W;

  localparam logic signed [CW-1:0] GMIN  = CW'(-G);
  localparam logic signed [CW-1:0] XLAST = CW'(G - 1);
  localparam logic signed [CW-1:0] YLAST = CW'(G);
  localparam logic [ERRW-1:0]      NOM   = ERRW'(tdoa_sdf_pkg::NO_MATCH);
  localparam logic signed [ZW-1:0] ZMAX  = ZW'(90 * 65536);
  localparam logic [AW-1:0]        QTR   = AW'(tdoa_sdf_pkg::QUARTER);
  localparam logic [AW-1:0]        FULL  = AW'(tdoa_sdf_pkg::FULL_CIRCLE);

  typedef struct packed {
    logic [VW-1:0] v;
    logic [RW-1:0] r;
  } sq_t;

  function automatic sq_t sq_step(input sq_t s, input int k);
    logic [RW-1:0] b;
    logic [RW-1:0] rb;
    sq_t           o;
    b  = RW'(1) << (2 * (NSTEP - 1 - k));
    rb = s.r + b;
    if ({1'b0, s.v} >= rb) begin
      o.v = s.v - rb[VW-1:0];
      o.r = (s.r >> 1) + b;
    end else begin
      o.v = s.v;
      o.r = s.r >> 1;
    end
    return o;
  endfunction

  // shift right rounding toward zero
  function automatic logic signed [CRW-1:0] shr0(input logic signed [CRW-1:0] v,
                                                input logic [ITW-1:0] s);
    logic signed [CRW-1:0] m;
    m = (v < 0) ? -v : v;
    m = m >> s;
    return (v < 0) ? -m : m;
  endfunction

  // configuration
  logic [tdoa_sdf_pkg::TP_W-1:0]  tp_q;
  logic [tdoa_sdf_pkg::TPU_W-1:0] tpu_q;
  logic [tdoa_sdf_pkg::THR_W-1:0] thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tp_q  <= tdoa_sdf_pkg::TP_RESET;
      tpu_q <= tdoa_sdf_pkg::TPU_RESET;
      thr_q <= tdoa_sdf_pkg::THR_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tdoa_sdf_pkg::CFG_TIMER_PERIOD:    tp_q  <= cfg_wdata_i[tdoa_sdf_pkg::TP_W-1:0];
        tdoa_sdf_pkg::CFG_TICKS_PER_UNIT:  tpu_q <= cfg_wdata_i[tdoa_sdf_pkg::TPU_W-1:0];
        tdoa_sdf_pkg::CFG_ANGLE_THRESHOLD: thr_q <= cfg_wdata_i[tdoa_sdf_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  // capture side
  logic [tdoa_sdf_pkg::RC_W-1:0] rc_q;
  logic [TB-1:0]                 arr_q [3];
  logic [2:0]                    flags_q;
  logic [1:0]                    mic_idx;
  logic [2:0]                    mic_bit;
  logic [PRODW-1:0]              prod;
  logic [TB-1:0]                 stamp;
  logic                          is_roll;
  logic                          triple;

  always_comb begin
    is_roll = (opcode_i == tdoa_sdf_pkg::OP_ROLLOVER);
    mic_idx = opcode_i - 2'd1;
    mic_bit = 3'b001 << mic_idx;
    prod    = PRODW'(rc_q) * PRODW'(tp_q);
    stamp   = TB'((PRODW + 1)'(prod) + (PRODW + 1)'(timer_value_i));
    triple  = !is_roll && ((flags_q | mic_bit) == 3'b111);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rc_q     <= '0;
      arr_q[0] <= '0;
      arr_q[1] <= '0;
      arr_q[2] <= '0;
      flags_q  <= '0;
    end else if (cmd_i.accept) begin
      if (is_roll) begin
        rc_q <= rc_q + 1'b1;
      end else begin
        arr_q[mic_idx] <= stamp;
        flags_q        <= triple ? 3'b000 : (flags_q | mic_bit);
      end
    end
  end

  // grid point generator
  logic signed [CW-1:0] x_q, y_q;
  logic                 gen_last;

  assign gen_last = (x_q == XLAST) && (y_q == YLAST);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q <= GMIN;
      y_q <= GMIN;
    end else if (cmd_i.prep) begin
      x_q <= GMIN;
      y_q <= GMIN;
    end else if (cmd_i.issue) begin
      if (x_q == XLAST) begin
        x_q <= GMIN;
        y_q <= y_q + 1'b1;
      end else begin
        x_q <= x_q + 1'b1;
      end
    end
  end

  // squared distances to the three microphones
  logic signed [CW:0]     gx0, gx1, gy0, gy1;
  logic signed [2*CW+1:0] sx0, sx1, sy0, sy1;
  logic [SQW-1:0]         q1, q2, q3;

  always_comb begin
    gx0 = {x_q[CW-1], x_q};
    gy0 = {y_q[CW-1], y_q};
    gx1 = gx0 + 1'b1;
    gy1 = gy0 + 1'b1;
    sx0 = gx0 * gx0;
    sx1 = gx1 * gx1;
    sy0 = gy0 * gy0;
    sy1 = gy1 * gy1;
    q1  = sx0[SQW-1:0] + sy0[SQW-1:0];
    q2  = sx1[SQW-1:0] + sy0[SQW-1:0];
    q3  = sx1[SQW-1:0] + sy1[SQW-1:0];
  end

  // time differences, 1/256 tick
  logic signed [TW-1:0] t_q [3];

  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      t_q[0] <= $signed({arr_q[0] - arr_q[1], 8'b0});
      t_q[1] <= $signed({arr_q[1] - arr_q[2], 8'b0});
      t_q[2] <= $signed({arr_q[0] - arr_q[2], 8'b0});
    end
  end

  // search pipeline: sqrt stages, product, abs, sum
  logic [NS-1:0]         vld_q;
  sq_t                   sq_q [NSTEP+1][3];
  logic signed [CW-1:0]  px_q [NS];
  logic signed [CW-1:0]  py_q [NS];
  logic signed [PW-1:0]  pm_q [3];
  logic [EW-1:0]         ab_q [3];
  logic [SUMW-1:0]       sm_q;

  logic [DW-1:0]                      d1, d2, d3;
  logic signed [DW:0]                 dd [3];
  logic signed [tdoa_sdf_pkg::TPU_W:0] tpu_s;
  logic signed [EW-1:0]               ev [3];
  logic [EW+1:0]                      tot;

  always_comb begin
    d1    = sq_q[NSTEP][0].r[DW-1:0];
    d2    = sq_q[NSTEP][1].r[DW-1:0];
    d3    = sq_q[NSTEP][2].r[DW-1:0];
    dd[0] = $signed({1'b0, d1}) - $signed({1'b0, d2});
    dd[1] = $signed({1'b0, d2}) - $signed({1'b0, d3});
    dd[2] = $signed({1'b0, d1}) - $signed({1'b0, d3});
    tpu_s = $signed({1'b0, tpu_q});
    for (int u = 0; u < 3; u++) begin
      ev[u] = EW'(pm_q[u]) - EW'(t_q[u]);
    end
    tot = {2'b00, ab_q[0]} + {2'b00, ab_q[1]} + {2'b00, ab_q[2]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[NS-2:0], cmd_i.issue};
    end
  end

  always_ff @(posedge clk_i) begin
    px_q[0]    <= x_q;
    py_q[0]    <= y_q;
    sq_q[0][0] <= '{v: {q1, 16'b0}, r: '0};
    sq_q[0][1] <= '{v: {q2, 16'b0}, r: '0};
    sq_q[0][2] <= '{v: {q3, 16'b0}, r: '0};
    for (int k = 1; k <= NSTEP; k++) begin
      for (int u = 0; u < 3; u++) begin
        sq_q[k][u] <= sq_step(sq_q[k-1][u], k - 1);
      end
    end
    for (int k = 1; k < NS; k++) begin
      px_q[k] <= px_q[k-1];
      py_q[k] <= py_q[k-1];
    end
    for (int u = 0; u < 3; u++) begin
      pm_q[u] <= dd[u] * tpu_s;
      ab_q[u] <= (ev[u] < 0) ? unsigned'(-ev[u]) : unsigned'(ev[u]);
    end
    sm_q <= tot[EW+1:8];
  end

  // running minimum, strictly lower wins
  logic [ERRW-1:0]      best_q;
  logic signed [CW-1:0] bx_q, by_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q <= NOM;
      bx_q   <= '0;
      by_q   <= '0;
    end else if (cmd_i.prep) begin
      best_q <= NOM;
      bx_q   <= '0;
      by_q   <= '0;
    end else if (vld_q[NS-1] && (sm_q < SUMW'(best_q))) begin
      best_q <= sm_q[ERRW-1:0];
      bx_q   <= px_q[NS-1];
      by_q   <= py_q[NS-1];
    end
  end

  // CORDIC vectoring on |x|, |y|
  logic signed [CRW-1:0] cx_q, cy_q, sxs, sys;
  logic signed [ZW-1:0]  z_q, at;
  logic [ITW-1:0]        it_q;
  logic [CW-1:0]         abx, aby;

  always_comb begin
    abx = (bx_q < 0) ? unsigned'(-bx_q) : unsigned'(bx_q);
    aby = (by_q < 0) ? unsigned'(-by_q) : unsigned'(by_q);
    sxs = shr0(cx_q, it_q);
    sys = shr0(cy_q, it_q);
    at  = ZW'(tdoa_sdf_pkg::atan_entry(it_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      it_q <= '0;
    end else if (cmd_i.cordic_start) begin
      it_q <= '0;
    end else if (cmd_i.cordic_step) begin
      it_q <= it_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cordic_start) begin
      cx_q <= signed'(CRW'(abx) << tdoa_sdf_pkg::CRD_FRAC);
      cy_q <= signed'(CRW'(aby) << tdoa_sdf_pkg::CRD_FRAC);
      z_q  <= '0;
    end else if (cmd_i.cordic_step) begin
      if (cy_q > 0) begin
        cx_q <= cx_q + sys;
        cy_q <= cy_q - sxs;
        z_q  <= z_q + at;
      end else begin
        cx_q <= cx_q - sys;
        cy_q <= cy_q + sxs;
        z_q  <= z_q - at;
      end
    end
  end

  // clamp, round to 1/256 degree, place in quadrant
  logic signed [ZW-1:0] zc;
  logic [ZW-1:0]        zr;
  logic [AW-1:0]        aq, ang_d, ang_q;

  always_comb begin
    if (z_q < 0) begin
      zc = '0;
    end else if (z_q > ZMAX) begin
      zc = ZMAX;
    end else begin
      zc = z_q;
    end
    zr = unsigned'(zc) + ZW'(128);
    aq = AW'(zr >> 8);
    if (bx_q == 0) begin
      ang_d = (by_q > 0) ? QTR : ((by_q < 0) ? AW'(3 * tdoa_sdf_pkg::QUARTER) : '0);
    end else if (by_q == 0) begin
      ang_d = (bx_q > 0) ? '0 : AW'(2 * tdoa_sdf_pkg::QUARTER);
    end else if (bx_q > 0 && by_q > 0) begin
      ang_d = aq;
    end else if (by_q > 0) begin
      ang_d = AW'(2 * tdoa_sdf_pkg::QUARTER) - aq;
    end else if (bx_q < 0) begin
      ang_d = AW'(2 * tdoa_sdf_pkg::QUARTER) + aq;
    end else begin
      ang_d = (aq == '0) ? '0 : FULL - aq;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.map) begin
      ang_q <= ang_d;
    end
  end

  // hysteresis and result register
  logic [AW-1:0]                        prev_q;
  logic signed [tdoa_sdf_pkg::ROT_W-1:0] last_q, dang, rot;
  logic [tdoa_sdf_pkg::ROT_W-1:0]       adang;
  logic                                 out_valid_q;

  always_comb begin
    dang  = $signed({1'b0, ang_q}) - $signed({1'b0, prev_q});
    adang = (dang < 0) ? unsigned'(-dang) : unsigned'(dang);
    if (adang > {1'b0, thr_q}) begin
      rot = dang;
    end else if (adang < {1'b0, thr_q}) begin
      rot = '0;
    end else begin
      rot = last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q      <= '0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.finish) begin
        last_q      <= rot;
        out_valid_q <= 1'b1;
        if (adang > {1'b0, thr_q}) begin
          prev_q <= ang_q;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      angle_deg_o  <= ang_q;
      rotate_deg_o <= rot;
      best_x_o     <= tdoa_sdf_pkg::XY_W'(bx_q);
      best_y_o     <= tdoa_sdf_pkg::XY_W'(by_q);
      min_error_o  <= best_q;
    end
  end

  assign out_valid_o = out_valid_q;

  always_comb begin
    sts_o.triple      = triple;
    sts_o.gen_last    = gen_last;
    sts_o.pipe_empty  = (vld_q == '0);
    sts_o.cordic_last = (it_q == ITW'(tdoa_sdf_pkg::CRD_STEPS - 1));
    sts_o.out_free    = !out_valid_q || out_ready_i;
  end

  `TDOA_ASSERT_IMP(a_best_bounded, 1'b1, best_q <= NOM)
  `TDOA_ASSERT_NXT(a_prep_restart, cmd_i.prep, (best_q == NOM) && (x_q == GMIN) && (y_q == GMIN))

endmodule

[rtl/tdoa_sdf_ctrl.sv]
`timescale 1ns / 1ps
`include "tdoa_sound_direction_finder_unit_defines.svh"

module tdoa_sdf_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  tdoa_sdf_pkg::sts_t sts_i,
  output tdoa_sdf_pkg::cmd_t cmd_o
);

  tdoa_sdf_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tdoa_sdf_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      tdoa_sdf_pkg::S_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i && sts_i.triple) begin
          state_d = tdoa_sdf_pkg::S_PREP;
        end
      end
      tdoa_sdf_pkg::S_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = tdoa_sdf_pkg::S_SEARCH;
      end
      tdoa_sdf_pkg::S_SEARCH: begin
        cmd_o.issue = 1'b1;
        if (sts_i.gen_last) begin
          state_d = tdoa_sdf_pkg::S_DRAIN;
        end
      end
      tdoa_sdf_pkg::S_DRAIN: begin
        if (sts_i.pipe_empty) begin
          cmd_o.cordic_start = 1'b1;
          state_d            = tdoa_sdf_pkg::S_ANGLE;
        end
      end
      tdoa_sdf_pkg::S_ANGLE: begin
        cmd_o.cordic_step = 1'b1;
        if (sts_i.cordic_last) begin
          state_d = tdoa_sdf_pkg::S_MAP;
        end
      end
      tdoa_sdf_pkg::S_MAP: begin
        cmd_o.map = 1'b1;
        state_d   = tdoa_sdf_pkg::S_DONE;
      end
      tdoa_sdf_pkg::S_DONE: begin
        // hold the result until the output register can take it
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = tdoa_sdf_pkg::S_IDLE;
        end
      end
      default: state_d = tdoa_sdf_pkg::S_IDLE;
    endcase
  end

  `TDOA_ASSERT_NXT(a_search_holds, (state_q == tdoa_sdf_pkg::S_SEARCH) && !sts_i.gen_last, state_q == tdoa_sdf_pkg::S_SEARCH)
  `TDOA_ASSERT_NXT(a_drain_to_angle, (state_q == tdoa_sdf_pkg::S_DRAIN) && sts_i.pipe_empty, state_q == tdoa_sdf_pkg::S_ANGLE)
  `TDOA_ASSERT_NXT(a_done_waits, (state_q == tdoa_sdf_pkg::S_DONE) && !sts_i.out_free, state_q == tdoa_sdf_pkg::S_DONE)

endmodule

[rtl/tdoa_sound_direction_finder_unit.sv]
`timescale 1ns / 1ps
// channel   dir  handshake      payload
// in_ch     in   valid/ready    opcode, timer_value
// out_ch    out  valid/ready    angle_deg, rotate_deg, best_x, best_y, min_error
// cfg       in   cfg_we_i       cfg_idx_i, cfg_wdata_i
//
// Rollovers and partial captures are accepted back to back.
// The capture that completes a triple starts a grid search of 3660 points, one issued per
// cycle into the distance/error pipeline (18 stages), then 16 CORDIC iterations, the
// quadrant mapping and, once the output register is free, the result register load.
// Input is not accepted during that run; a pending result in the output register does not
// block input. Reset is asynchronous, active low, and needs no clearing pass.

module tdoa_sound_direction_finder_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  tdoa_sdf_in_if.sink                        in_ch,
  tdoa_sdf_out_if.source                     out_ch,
  input  logic                               cfg_we_i,
  input  logic [tdoa_sdf_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [tdoa_sdf_pkg::CFG_W-1:0]     cfg_wdata_i
);

  tdoa_sdf_pkg::cmd_t cmd;
  tdoa_sdf_pkg::sts_t sts;

  tdoa_sdf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ch.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tdoa_sdf_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .opcode_i      (in_ch.opcode),
    .timer_value_i (in_ch.timer_value),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .out_ready_i   (out_ch.ready),
    .out_valid_o   (out_ch.valid),
    .angle_deg_o   (out_ch.angle_deg),
    .rotate_deg_o  (out_ch.rotate_deg),
    .best_x_o      (out_ch.best_x),
    .best_y_o      (out_ch.best_y),
    .min_error_o   (out_ch.min_error)
  );

endmodule

[dv/tb_tdoa_sound_direction_finder_unit.sv]
`timescale 1ns / 1ps

module tb_tdoa_sound_direction_finder_unit;

  localparam int LIMIT_CYCLES = 1000000;
  localparam int HOLD_CYCLES  = 12000;
  localparam logic [tdoa_sdf_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

  typedef struct {
    logic [16:0]        angle;
    logic signed [17:0] rotate;
    logic signed [5:0]  bx;
    logic signed [5:0]  by;
    logic [19:0]        err;
  } bearing_fix_t;

  // Models the direction finder and holds the bearings still owed by the block.
  class bearing_board;
    bearing_fix_t                          pending_fixes[$];
    int                                    errors;
    logic [tdoa_sdf_pkg::TP_W-1:0]         period;
    logic [tdoa_sdf_pkg::TPU_W-1:0]        tpu;
    logic [tdoa_sdf_pkg::THR_W-1:0]        thresh;
    logic [tdoa_sdf_pkg::RC_W-1:0]         rollovers;
    logic [31:0]                           stamp[3];
    logic [2:0]                            arrived;
    longint                                prev_angle;
    longint                                last_rot;
    longint                                dist_tab[63][63];
    longint                                atan_deg[16];

    function new();
      longint v, r, b;
      atan_deg = '{2949120, 1740967, 919879, 466945, 234379, 117305, 58666, 29335,
                   14668, 7334, 3667, 1833, 917, 458, 229, 115};
      // 6.8 distances for every offset the search can reach
      for (int dx = -31; dx <= 31; dx++) begin
        for (int dy = -31; dy <= 31; dy++) begin
          v = longint'(dx * dx + dy * dy) << 16;
          r = 0;
          b = 64'sd1 << 62;
          while (b > v) b = b >> 2;
          while (b != 0) begin
            if (v >= r + b) begin
              v = v - (r + b);
              r = (r >> 1) + b;
            end else begin
              r = r >> 1;
            end
            b = b >> 2;
          end
          dist_tab[dx + 31][dy + 31] = r;
        end
      end
      errors     = 0;
      period     = tdoa_sdf_pkg::TP_RESET;
      tpu        = tdoa_sdf_pkg::TPU_RESET;
      thresh     = tdoa_sdf_pkg::THR_RESET;
      rollovers  = '0;
      stamp      = '{32'd0, 32'd0, 32'd0};
      arrived    = '0;
      prev_angle = 0;
      last_rot   = 0;
    endfunction

    function void write_reg(logic [tdoa_sdf_pkg::CFG_IDX_W-1:0] idx,
                            logic [tdoa_sdf_pkg::CFG_W-1:0] data);
      case (idx)
        tdoa_sdf_pkg::CFG_TIMER_PERIOD:    period = data;
        tdoa_sdf_pkg::CFG_TICKS_PER_UNIT:  tpu = data[tdoa_sdf_pkg::TPU_W-1:0];
        tdoa_sdf_pkg::CFG_ANGLE_THRESHOLD: thresh = data;
        default: ;
      endcase
    endfunction

    function longint abs_l(longint v);
      return v < 0 ? -v : v;
    endfunction

    function longint trunc_shr(longint v, int s);
      return v < 0 ? -((-v) >>> s) : v >>> s;
    endfunction

    function longint first_quadrant(longint ax, longint ay);
      longint cx, cy, z, sx, sy;
      cx = ax << 20;
      cy = ay << 20;
      z = 0;
      for (int i = 0; i < 16; i++) begin
        sx = trunc_shr(cx, i);
        sy = trunc_shr(cy, i);
        if (cy > 0) begin
          cx = cx + sy;
          cy = cy - sx;
          z = z + atan_deg[i];
        end else begin
          cx = cx - sy;
          cy = cy + sx;
          z = z - atan_deg[i];
        end
      end
      if (z < 0) z = 0;
      if (z > 90 * 65536) z = 90 * 65536;
      return (z + 128) >>> 8;
    endfunction

    function longint heading(longint x, longint y);
      longint a;
      if (x == 0) begin
        return y > 0 ? tdoa_sdf_pkg::QUARTER : (y < 0 ? 3 * tdoa_sdf_pkg::QUARTER : 0);
      end
      if (y == 0) return x > 0 ? 0 : 2 * tdoa_sdf_pkg::QUARTER;
      a = first_quadrant(abs_l(x), abs_l(y));
      if (x > 0 && y > 0) return a;
      if (x < 0 && y > 0) return 2 * tdoa_sdf_pkg::QUARTER - a;
      if (x < 0) return 2 * tdoa_sdf_pkg::QUARTER + a;
      a = tdoa_sdf_pkg::FULL_CIRCLE - a;
      return a >= tdoa_sdf_pkg::FULL_CIRCLE ? 0 : a;
    endfunction

    function bearing_fix_t locate();
      bearing_fix_t f;
      longint t12, t23, t13, k, best, bx, by, d1, d2, d3, e, ang, d, rot;
      t12 = longint'(int'(stamp[0] - stamp[1])) * 256;
      t23 = longint'(int'(stamp[1] - stamp[2])) * 256;
      t13 = longint'(int'(stamp[0] - stamp[2])) * 256;
      k = longint'(tpu);
      best = tdoa_sdf_pkg::NO_MATCH;
      bx = 0;
      by = 0;
      for (int y = -tdoa_sdf_pkg::GRID_HALF; y <= tdoa_sdf_pkg::GRID_HALF; y++) begin
        for (int x = -tdoa_sdf_pkg::GRID_HALF; x < tdoa_sdf_pkg::GRID_HALF; x++) begin
          d1 = dist_tab[x + 31][y + 31];
          d2 = dist_tab[x + 32][y + 31];
          d3 = dist_tab[x + 32][y + 32];
          e = (abs_l((d1 - d2) * k - t12) + abs_l((d2 - d3) * k - t23)
               + abs_l((d1 - d3) * k - t13)) >>> 8;
          if (e < best) begin
            best = e;
            bx = x;
            by = y;
          end
        end
      end
      ang = heading(bx, by);
      d = ang - prev_angle;
      if (abs_l(d) > longint'(thresh)) begin
        rot = d;
        prev_angle = ang;
      end else if (abs_l(d) < longint'(thresh)) begin
        rot = 0;
      end else begin
        rot = last_rot;
      end
      last_rot = rot;
      f.angle  = ang[16:0];
      f.rotate = rot[17:0];
      f.bx     = bx[5:0];
      f.by     = by[5:0];
      f.err    = best[19:0];
      return f;
    endfunction

    function void note_input(tdoa_sdf_pkg::op_e op, logic [15:0] tv);
      int m;
      if (op == tdoa_sdf_pkg::OP_ROLLOVER) begin
        rollovers = rollovers + 1'b1;
        return;
      end
      m = int'(op) - 1;
      stamp[m] = 32'(longint'(tv) + longint'(rollovers) * longint'(period));
      arrived[m] = 1'b1;
      if (arrived == 3'b111) begin
        arrived = '0;
        pending_fixes.push_back(locate());
      end
    endfunction

    function void check_fix(bearing_fix_t act);
      bearing_fix_t exp;
      if (pending_fixes.size() == 0) begin
        errors++;
        $display("%0t: unexpected result angle=%0d", $time, act.angle);
        return;
      end
      exp = pending_fixes.pop_front();
      if (act.angle !== exp.angle) begin
        errors++;
        $display("%0t: angle_deg exp %0d act %0d", $time, exp.angle, act.angle);
      end
      if (act.rotate !== exp.rotate) begin
        errors++;
        $display("%0t: rotate_deg exp %0d act %0d", $time, exp.rotate, act.rotate);
      end
      if (act.bx !== exp.bx) begin
        errors++;
        $display("%0t: best_x exp %0d act %0d", $time, exp.bx, act.bx);
      end
      if (act.by !== exp.by) begin
        errors++;
        $display("%0t: best_y exp %0d act %0d", $time, exp.by, act.by);
      end
      if (act.err !== exp.err) begin
        errors++;
        $display("%0t: min_error exp %0d act %0d", $time, exp.err, act.err);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [tdoa_sdf_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [tdoa_sdf_pkg::CFG_W-1:0]     cfg_wdata_i;

  tdoa_sdf_in_if  in_ch ();
  tdoa_sdf_out_if out_ch ();

  tdoa_sound_direction_finder_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  bearing_board board;
  bit steady;     // no idling on either side
  bit hold_go;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk_i);
    $display("RESULT: ERROR");
    $finish;
  end

  // result side
  initial begin
    bearing_fix_t act;
    int hold_left;
    hold_left = HOLD_CYCLES;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_ch.valid && out_ch.ready) begin
        act.angle  = out_ch.angle_deg;
        act.rotate = out_ch.rotate_deg;
        act.bx     = out_ch.best_x;
        act.by     = out_ch.best_y;
        act.err    = out_ch.min_error;
        board.check_fix(act);
      end
      if (hold_go && hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= steady || ($urandom_range(0, 99) >= 27);
      end
    end
  end

  task automatic send_item(tdoa_sdf_pkg::op_e op, logic [15:0] tv);
    while (!steady && $urandom_range(0, 99) < 27) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid       <= 1'b1;
    in_ch.opcode      <= op;
    in_ch.timer_value <= tv;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    board.note_input(op, tv);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (board.pending_fixes.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [tdoa_sdf_pkg::CFG_IDX_W-1:0] idx,
                           logic [tdoa_sdf_pkg::CFG_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    board.write_reg(idx, data);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_regs(logic [tdoa_sdf_pkg::CFG_W-1:0] tp, logic [tdoa_sdf_pkg::CFG_W-1:0] k,
                          logic [tdoa_sdf_pkg::CFG_W-1:0] thr);
    settle();
    write_reg(tdoa_sdf_pkg::CFG_TIMER_PERIOD, tp);
    write_reg(tdoa_sdf_pkg::CFG_TICKS_PER_UNIT, k);
    write_reg(tdoa_sdf_pkg::CFG_ANGLE_THRESHOLD, thr);
  endtask

  // one acoustic event: three captures in random order with plausible spacing,
  // sometimes a rollover in between; a fraction is noise instead
  task automatic send_event();
    logic [15:0] base;
    int spread, order[3], j, tmp;
    base = 16'($urandom);
    spread = int'(board.tpu) * 2 + 1;
    if (spread > 65535) spread = 65535;
    order = '{1, 2, 3};
    for (int i = 2; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    if ($urandom_range(0, 99) < 15) begin
      repeat ($urandom_range(1, 3)) begin
        send_item(tdoa_sdf_pkg::op_e'($urandom_range(0, 3)), 16'($urandom));
      end
      return;
    end
    for (int i = 0; i < 3; i++) begin
      if ($urandom_range(0, 99) < 10) send_item(tdoa_sdf_pkg::OP_ROLLOVER, 16'($urandom));
      send_item(tdoa_sdf_pkg::op_e'(order[i]), base + 16'($urandom_range(0, spread)));
    end
  endtask

  initial begin
    board = new();
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    in_ch.valid = 1'b0;
    in_ch.opcode = tdoa_sdf_pkg::OP_ROLLOVER;
    in_ch.timer_value = '0;
    steady = 1'b0;
    hold_go = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: equal arrivals, extremes, repeated capture, rollovers
    send_item(tdoa_sdf_pkg::OP_MIC1, 16'd0);
    send_item(tdoa_sdf_pkg::OP_MIC2, 16'd0);
    send_item(tdoa_sdf_pkg::OP_MIC3, 16'd0);
    send_item(tdoa_sdf_pkg::OP_MIC2, 16'hFFFF);
    send_item(tdoa_sdf_pkg::OP_MIC1, 16'd0);
    send_item(tdoa_sdf_pkg::OP_MIC1, 16'd100);
    send_item(tdoa_sdf_pkg::OP_MIC3, 16'd30000);
    send_item(tdoa_sdf_pkg::OP_ROLLOVER, 16'hFFFF);
    send_item(tdoa_sdf_pkg::OP_MIC1, 16'd7059);
    send_item(tdoa_sdf_pkg::OP_MIC2, 16'd0);
    send_item(tdoa_sdf_pkg::OP_ROLLOVER, 16'd0);
    send_item(tdoa_sdf_pkg::OP_MIC3, 16'd500);
    // zero period, zero ticks per unit, zero threshold: repeated angle hits the tie
    set_regs(17'd0, 17'd0, 17'd0);
    write_reg(CFG_UNMAPPED, 17'h1FFFF);
    send_item(tdoa_sdf_pkg::OP_ROLLOVER, 16'd1);
    send_item(tdoa_sdf_pkg::OP_MIC3, 16'd40);
    send_item(tdoa_sdf_pkg::OP_MIC2, 16'd20);
    send_item(tdoa_sdf_pkg::OP_MIC1, 16'd10);
    send_item(tdoa_sdf_pkg::OP_MIC1, 16'd10);
    send_item(tdoa_sdf_pkg::OP_MIC2, 16'd20);
    send_item(tdoa_sdf_pkg::OP_MIC3, 16'd40);
    set_regs(17'h1FFFF, 17'd65535, 17'h1FFFF);
    send_item(tdoa_sdf_pkg::OP_MIC1, 16'hFFFF);
    send_item(tdoa_sdf_pkg::OP_ROLLOVER, 16'd0);
    send_item(tdoa_sdf_pkg::OP_MIC2, 16'd0);
    send_item(tdoa_sdf_pkg::OP_MIC3, 16'h8000);

    // random traffic over several register settings
    set_regs(17'd16000, 17'd7059, 17'd1280);
    repeat (9) send_event();
    steady = 1'b1;
    repeat (6) send_event();
    steady = 1'b0;
    hold_go = 1'b1;
    repeat (6) send_event();
    set_regs(17'd1, 17'd1, 17'd0);
    repeat (5) send_event();
    set_regs(17'd65536, 17'd200, 17'd92160);
    repeat (5) send_event();
    set_regs(17'($urandom_range(1, 65536)), 17'($urandom_range(1, 65535)),
             17'($urandom_range(0, 4000)));
    repeat (6) send_event();
    settle();
    repeat (50) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
